/* design/psq_pkg.sv */
`timescale 1ns / 1ps

package psq_pkg;

   localparam int TIMEOUT_W   = 20;
   localparam int DROP_W      = 4;
   localparam int MPP_W       = 24;
   localparam int PERIOD_W    = 16;
   localparam int ELAPSED_W   = 16;
   localparam int COUNT_W     = 32;
   localparam int SINCE_W     = 24;
   localparam int SPEED_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd655;
   localparam logic [DROP_W-1:0]    DROP_RESET    = 4'd3;
   localparam logic [MPP_W-1:0]     MPP_RESET     = 24'd0;

   localparam logic KIND_PULSE = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT = 2'd0,
      CSR_DROP    = 2'd1,
      CSR_MPP     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout;
      logic [DROP_W-1:0]    drop;
      logic [MPP_W-1:0]     mpp;
   } cfg_type;

   // One qualified tick handed from the front to the back.
   typedef struct packed {
      logic [COUNT_W-1:0]  path;
      logic [PERIOD_W-1:0] period;
      logic                valid;
   } tick_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

/* design/pulse_speedometer_qualifier.sv */
`timescale 1ns / 1ps

// Pulse speedometer qualifier.
// Input queue side: push a transaction with req_kind = 0 for a captured wheel
// pulse (req_period valid) or req_kind = 1 for an update tick (req_elapsed
// valid); it is taken on a clock edge with req_push high and req_full low.
// Pulses update the counters and give no result. Each tick gives one result
// on the rsp_ side: pulse count, speed (Q16.16 m/s) and the valid flag; the
// oldest result is shown while rsp_empty is low and leaves on rsp_pop.
// The front takes one transaction per cycle while req_full is low and
// classifies ticks at once; ticks then wait in a two-entry queue for the
// back, which computes meters_per_pulse * TIMER_FREQ / period with a
// radix-4 restoring divider. A computed tick passes through the back's
// multiply, divide and done states; invalid readings and zero periods skip
// the divider, going from idle straight to done. The divider sets the
// sustained tick rate.
// When the receiver stalls, results hold in the output register, the back
// holds its finished result, and the queue fills until req_full rises; pulses
// are refused then too. Reset is synchronous: it restores the register
// defaults, clears counts and the queue, and sets the stale time to twice
// the timeout. CSR writes take effect on the next edge, with no read-back.
module pulse_speedometer_qualifier #(
   parameter int TIMER_FREQ = 50000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [psq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_kind,
   input  logic [psq_pkg::PERIOD_W-1:0]      req_period,
   input  logic [psq_pkg::ELAPSED_W-1:0]     req_elapsed,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic [psq_pkg::COUNT_W-1:0]       rsp_path,
   output logic [psq_pkg::SPEED_W-1:0]       rsp_speed,
   output logic                              rsp_valid_res
);

   psq_pkg::cfg_type  cfg_ff;
   psq_pkg::tick_type push_data;
   psq_pkg::tick_type pop_data;
   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;

   // Register file: mask each write to its field width, ignore unused indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout <= psq_pkg::TIMEOUT_RESET;
         cfg_ff.drop    <= psq_pkg::DROP_RESET;
         cfg_ff.mpp     <= psq_pkg::MPP_RESET;
      end else if (csr_we) begin
         case (psq_pkg::csr_index_type'(csr_index))
            psq_pkg::CSR_TIMEOUT: cfg_ff.timeout <= csr_wdata[psq_pkg::TIMEOUT_W-1:0];
            psq_pkg::CSR_DROP:    cfg_ff.drop    <= csr_wdata[psq_pkg::DROP_W-1:0];
            psq_pkg::CSR_MPP:     cfg_ff.mpp     <= csr_wdata[psq_pkg::MPP_W-1:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Front: count pulses, age the stale timer, run the validity machine.
   psq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_period  (req_period),
      .req_elapsed (req_elapsed),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (push_data)
   );

   // Decouple the front, which classifies each tick as it is taken, from the iterative divider.
   psq_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (push_data),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (pop_data),
      .empty (q_empty)
   );

   // Back: multiply, divide, saturate and hold the result for the receiver.
   psq_back #(
      .TIMER_FREQ (TIMER_FREQ)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_mpp       (cfg_ff.mpp),
      .q_empty       (q_empty),
      .q_data        (pop_data),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_path      (rsp_path),
      .rsp_speed     (rsp_speed),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

/* design/psq_front.sv */
`timescale 1ns / 1ps

module psq_front (
   input  logic                              clock,
   input  logic                              reset,
   input  psq_pkg::cfg_type                  cfg,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_kind,
   input  logic [psq_pkg::PERIOD_W-1:0]      req_period,
   input  logic [psq_pkg::ELAPSED_W-1:0]     req_elapsed,
   input  logic                              q_full,
   output logic                              q_push,
   output psq_pkg::tick_type                 q_data
);

   localparam int SUM_W = psq_pkg::SINCE_W + 1;

   logic [psq_pkg::COUNT_W-1:0]  pulse_total_ff, pulse_total_in;
   logic [psq_pkg::PERIOD_W-1:0] last_period_ff, last_period_in;
   logic [psq_pkg::COUNT_W-1:0]  seen_total_ff, seen_total_in;
   logic [psq_pkg::SINCE_W-1:0]  since_ff, since_in;
   logic [psq_pkg::DROP_W-1:0]   fresh_ff, fresh_in;
   logic                         qual_ff, qual_in;

   logic                         accept;
   logic [SUM_W-1:0]             sum;
   logic [SUM_W-1:0]             triple;
   logic [SUM_W-1:0]             twice;
   logic [psq_pkg::DROP_W:0]     fresh_inc;
   logic [psq_pkg::SINCE_W-1:0]  since_tick;
   logic [psq_pkg::DROP_W-1:0]   fresh_tick;
   logic [psq_pkg::SINCE_W-1:0]  timeout_ext;
   logic                         tick_valid;

   assign req_full    = q_full;
   assign accept      = req_push && !q_full;
   assign timeout_ext = psq_pkg::SINCE_W'(cfg.timeout);

   always_comb begin
      sum       = SUM_W'(since_ff) + SUM_W'(req_elapsed);
      twice     = SUM_W'(cfg.timeout) << 1;
      triple    = twice + SUM_W'(cfg.timeout);
      fresh_inc = (psq_pkg::DROP_W + 1)'(fresh_ff) + 1'b1;
      if (seen_total_ff == pulse_total_ff) begin
         since_tick = (sum > triple) ? twice[psq_pkg::SINCE_W-1:0]
                                     : sum[psq_pkg::SINCE_W-1:0];
         fresh_tick = fresh_ff;
      end else begin
         since_tick = '0;
         fresh_tick = (fresh_inc > (psq_pkg::DROP_W + 1)'(cfg.drop)) ? cfg.drop
                                     : fresh_inc[psq_pkg::DROP_W-1:0];
      end
      if (!qual_ff) begin
         tick_valid = (since_tick < timeout_ext) && (fresh_tick >= cfg.drop);
      end else begin
         tick_valid = !(since_tick > timeout_ext);
      end
   end

   always_comb begin
      pulse_total_in = pulse_total_ff;
      last_period_in = last_period_ff;
      seen_total_in  = seen_total_ff;
      since_in       = since_ff;
      fresh_in       = fresh_ff;
      qual_in        = qual_ff;
      if (accept && req_kind == psq_pkg::KIND_PULSE) begin
         pulse_total_in = pulse_total_ff + 1'b1;
         last_period_in = req_period;
      end else if (accept) begin
         seen_total_in = pulse_total_ff;
         since_in      = since_tick;
         qual_in       = tick_valid;
         // drop out of the qualified state clears the fresh-pulse count
         fresh_in      = (qual_ff && !tick_valid) ? '0 : fresh_tick;
      end
   end

   assign q_push        = accept && req_kind == psq_pkg::KIND_TICK;
   assign q_data.path   = pulse_total_ff;
   assign q_data.period = last_period_ff;
   assign q_data.valid  = tick_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_total_ff <= '0;
         last_period_ff <= '0;
         seen_total_ff  <= '0;
         since_ff       <= psq_pkg::SINCE_W'(psq_pkg::TIMEOUT_RESET) << 1;
         fresh_ff       <= '0;
         qual_ff        <= 1'b0;
      end else begin
         pulse_total_ff <= pulse_total_in;
         last_period_ff <= last_period_in;
         seen_total_ff  <= seen_total_in;
         since_ff       <= since_in;
         fresh_ff       <= fresh_in;
         qual_ff        <= qual_in;
      end
   end

endmodule

/* design/psq_fifo.sv */
`timescale 1ns / 1ps

module psq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  psq_pkg::tick_type wdata,
   output logic              full,
   input  logic              pop,
   output psq_pkg::tick_type rdata,
   output logic              empty
);

   localparam int PTR_W = $clog2(psq_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(psq_pkg::QUEUE_DEPTH + 1);

   psq_pkg::tick_type    slot_ff [psq_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = count_ff == CNT_W'(psq_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(psq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(psq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/psq_back.sv */
`timescale 1ns / 1ps

module psq_back #(
   parameter int TIMER_FREQ = 50000
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [psq_pkg::MPP_W-1:0]      cfg_mpp,
   input  logic                           q_empty,
   input  psq_pkg::tick_type              q_data,
   output logic                           q_pop,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output logic [psq_pkg::COUNT_W-1:0]    rsp_path,
   output logic [psq_pkg::SPEED_W-1:0]    rsp_speed,
   output logic                           rsp_valid_res
);

   localparam int FREQ_W = $clog2(TIMER_FREQ + 1);
   localparam int NUM_W  = psq_pkg::MPP_W + FREQ_W;
   localparam int ITERS  = (NUM_W + 1) / 2;
   localparam int DIV_W  = 2 * ITERS;
   localparam int CNT_W  = $clog2(ITERS);
   localparam int REM_W  = psq_pkg::PERIOD_W;

   psq_pkg::back_state_type state_ff, state_in;
   psq_pkg::tick_type       entry_ff;
   logic [DIV_W-1:0]        num_ff, num_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    out_full_ff;
   logic [psq_pkg::COUNT_W-1:0] path_ff;
   logic [psq_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic                    valid_ff;

   logic                    load_out;
   logic                    div_last;
   logic                    skip;
   logic [NUM_W-1:0]        product;
   logic [REM_W:0]          r1, r1s, r2, r2s;
   logic                    ge1, ge2;

   assign div_last = cnt_ff == CNT_W'(ITERS - 1);
   assign skip     = !q_data.valid || q_data.period == '0;
   assign product  = NUM_W'(cfg_mpp) * NUM_W'(TIMER_FREQ);

   // Two restoring quotient bits per cycle; the quotient shifts into the dividend register.
   always_comb begin
      r1     = {rem_ff, num_ff[DIV_W-1]};
      ge1    = r1 >= (REM_W + 1)'(entry_ff.period);
      r1s    = ge1 ? r1 - (REM_W + 1)'(entry_ff.period) : r1;
      r2     = {r1s[REM_W-1:0], num_ff[DIV_W-2]};
      ge2    = r2 >= (REM_W + 1)'(entry_ff.period);
      r2s    = ge2 ? r2 - (REM_W + 1)'(entry_ff.period) : r2;
      rem_in = r2s[REM_W-1:0];
      num_in = {num_ff[DIV_W-3:0], ge1, ge2};
   end

   always_comb begin
      if (!entry_ff.valid || entry_ff.period == '0) begin
         speed_in = '0;
      end else if (|num_ff[DIV_W-1:psq_pkg::SPEED_W]) begin
         speed_in = '1;
      end else begin
         speed_in = num_ff[psq_pkg::SPEED_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psq_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = skip ? psq_pkg::BK_DONE : psq_pkg::BK_MUL;
            end
         end
         psq_pkg::BK_MUL: state_in = psq_pkg::BK_DIV;
         psq_pkg::BK_DIV: begin
            if (div_last) begin
               state_in = psq_pkg::BK_DONE;
            end
         end
         psq_pkg::BK_DONE: begin
            if (!out_full_ff || rsp_pop) begin
               state_in = psq_pkg::BK_IDLE;
            end
         end
         default: state_in = psq_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         psq_pkg::BK_IDLE: q_pop    = !q_empty;
         psq_pkg::BK_DONE: load_out = !out_full_ff || rsp_pop;
         default: begin
            q_pop    = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         entry_ff <= q_data;
      end
      if (state_ff == psq_pkg::BK_MUL) begin
         num_ff <= DIV_W'(product);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == psq_pkg::BK_DIV) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (load_out) begin
         path_ff  <= entry_ff.path;
         speed_ff <= speed_in;
         valid_ff <= entry_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= psq_pkg::BK_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_full_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty     = !out_full_ff;
   assign rsp_path      = path_ff;
   assign rsp_speed     = speed_ff;
   assign rsp_valid_res = valid_ff;

endmodule
